>>> rtl/pal_pkg.sv
// Shared types, opcodes and field widths for the positional array list.
package pal_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int ELEM_WIDTH_DEF = 32;

  localparam int OPC_W   = 3;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 5;
  localparam int IN_TD_W  = 40;
  localparam int OUT_TD_W = 40;

  typedef logic [OPC_W-1:0] opcode_t;

  localparam opcode_t OP_INS_SHIFT = 3'd0;
  localparam opcode_t OP_INS_FAST  = 3'd1;
  localparam opcode_t OP_PUSH      = 3'd2;
  localparam opcode_t OP_ERA_SHIFT = 3'd3;
  localparam opcode_t OP_ERA_FAST  = 3'd4;
  localparam opcode_t OP_POP       = 3'd5;
  localparam opcode_t OP_CLEAR     = 3'd6;
  localparam opcode_t OP_READ      = 3'd7;

  typedef logic [2:0] wr_mode_t;

  localparam wr_mode_t WR_NONE      = 3'd0;
  localparam wr_mode_t WR_INS_SHIFT = 3'd1;
  localparam wr_mode_t WR_INS_FAST  = 3'd2;
  localparam wr_mode_t WR_PUSH      = 3'd3;
  localparam wr_mode_t WR_ERA_SHIFT = 3'd4;
  localparam wr_mode_t WR_ERA_FAST  = 3'd5;

  typedef logic [1:0] cnt_op_t;

  localparam cnt_op_t CNT_HOLD = 2'd0;
  localparam cnt_op_t CNT_INC  = 2'd1;
  localparam cnt_op_t CNT_DEC  = 2'd2;
  localparam cnt_op_t CNT_CLR  = 2'd3;

  typedef struct packed {
    logic     ld_in;
    logic     rd_item;
    logic     rd_tmp;
    logic     rd_last;
    wr_mode_t wr_mode;
    cnt_op_t  cnt_op;
    logic     out_ld;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    ok;
  } sts_t;

endpackage

>>> rtl/positional_array_list_top.sv
// Positional array list: one beat in flight, taken only in the idle state. Insert shift, push
// back, pop, clear, read and any refused beat pass through exec and out; insert fast and erase
// shift add step2; erase fast adds step2 and step3, set by the single read port on the entry
// cells. A full result register that is not drained stalls the result load and the next beat.
// Shifts move all cells in parallel in a single write.
// Synchronous active-low reset empties the list; entry contents are not cleared.
module positional_array_list_top #(
  parameter int DEPTH      = pal_pkg::DEPTH_DEF,
  parameter int ELEM_WIDTH = pal_pkg::ELEM_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [pal_pkg::IN_TD_W-1:0]    in_tdata,   // position[4:0], value[36:5]
  input  pal_pkg::opcode_t               in_tuser,   // opcode[2:0]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [pal_pkg::OUT_TD_W-1:0]   out_tdata,  // ok[0], item_value[32:1], count[37:33]
  output logic                           out_tuser   // item_valid[0]
);
  import pal_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic              ok;
  logic [VAL_W-1:0]  item_value;
  logic [CNT_W-1:0]  count;

  pal_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pal_dpath #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_opcode      (in_tuser),
    .in_position    (in_tdata[POS_W-1:0]),
    .in_value       (in_tdata[POS_W+VAL_W-1:POS_W]),
    .cmd            (cmd),
    .sts            (sts),
    .out_ok         (ok),
    .out_item_valid (out_tuser),
    .out_item_value (item_value),
    .out_count      (count)
  );

  assign out_tdata = {{(OUT_TD_W - 1 - VAL_W - CNT_W){1'b0}}, count, item_value, ok};

endmodule

>>> rtl/pal_ctrl.sv
// Sequencing state machine for the positional array list.
module pal_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  pal_pkg::sts_t sts,
  output pal_pkg::cmd_t cmd
);
  import pal_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_STEP2 = 3'd2;
  localparam logic [2:0] ST_STEP3 = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       ovld_r, ovld_nxt;
  logic       out_free;

  assign out_free   = !ovld_r || out_tready;
  assign in_tready  = rst_n && (state_r == ST_IDLE);
  assign out_tvalid = ovld_r;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.wr_mode = WR_NONE;
    cmd.cnt_op  = CNT_HOLD;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.ld_in = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_OUT;
        if (sts.ok) begin
          case (sts.op)
            OP_INS_SHIFT: begin
              cmd.wr_mode = WR_INS_SHIFT;
              cmd.cnt_op  = CNT_INC;
            end
            OP_INS_FAST: begin
              cmd.rd_item = 1'b1;
              state_nxt   = ST_STEP2;
            end
            OP_PUSH: begin
              cmd.wr_mode = WR_PUSH;
              cmd.cnt_op  = CNT_INC;
            end
            OP_ERA_SHIFT, OP_ERA_FAST: begin
              cmd.rd_item = 1'b1;
              state_nxt   = ST_STEP2;
            end
            OP_POP: begin
              cmd.rd_item = 1'b1;
              cmd.rd_last = 1'b1;
              cmd.cnt_op  = CNT_DEC;
            end
            OP_CLEAR: begin
              cmd.cnt_op = CNT_CLR;
            end
            default: begin
              cmd.rd_item = 1'b1;
            end
          endcase
        end
      end
      ST_STEP2: begin
        state_nxt = ST_OUT;
        case (sts.op)
          OP_INS_FAST: begin
            cmd.wr_mode = WR_INS_FAST;
            cmd.cnt_op  = CNT_INC;
          end
          OP_ERA_SHIFT: begin
            cmd.wr_mode = WR_ERA_SHIFT;
            cmd.cnt_op  = CNT_DEC;
          end
          OP_ERA_FAST: begin
            cmd.rd_tmp  = 1'b1;
            cmd.rd_last = 1'b1;
            state_nxt   = ST_STEP3;
          end
          default: begin
            state_nxt = ST_OUT;
          end
        endcase
      end
      ST_STEP3: begin
        cmd.wr_mode = WR_ERA_FAST;
        cmd.cnt_op  = CNT_DEC;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ovld_nxt = ovld_r;
    if (out_tready) begin
      ovld_nxt = 1'b0;
    end
    if (cmd.out_ld) begin
      ovld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

endmodule

>>> rtl/pal_dpath.sv
// Entry cells, element count, read port and result register.
module pal_dpath #(
  parameter int DEPTH      = pal_pkg::DEPTH_DEF,
  parameter int ELEM_WIDTH = pal_pkg::ELEM_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pal_pkg::opcode_t             in_opcode,
  input  logic [pal_pkg::POS_W-1:0]    in_position,
  input  logic [pal_pkg::VAL_W-1:0]    in_value,
  input  pal_pkg::cmd_t                cmd,
  output pal_pkg::sts_t                sts,
  output logic                         out_ok,
  output logic                         out_item_valid,
  output logic [pal_pkg::VAL_W-1:0]    out_item_value,
  output logic [pal_pkg::CNT_W-1:0]    out_count
);
  import pal_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);

  logic [ELEM_WIDTH-1:0] ent_r   [DEPTH];
  logic [ELEM_WIDTH-1:0] ent_nxt [DEPTH];
  logic [ELEM_WIDTH-1:0] below   [DEPTH];
  logic [ELEM_WIDTH-1:0] above   [DEPTH];

  logic [CW-1:0]         cnt_r, cnt_nxt;
  opcode_t               op_r;
  logic                  ok_r, ok_nxt;
  logic [CMPW-1:0]       pos_r, pos_in;
  logic [ELEM_WIDTH-1:0] val_r;
  logic [ELEM_WIDTH-1:0] item_r, tmp_r, rdata;
  logic [CMPW-1:0]       n, last, rd_addr;
  logic                  iv;

  assign n       = CMPW'(cnt_r);
  assign last    = n - CMPW'(1);
  assign pos_in  = CMPW'(in_position);
  assign rd_addr = cmd.rd_last ? last : pos_r;
  assign rdata   = ent_r[rd_addr[AW-1:0]];

  assign sts.op = op_r;
  assign sts.ok = ok_r;

  always_comb begin
    case (in_opcode)
      OP_INS_SHIFT, OP_INS_FAST: ok_nxt = (pos_in <= n) && (n < DEPTH_C);
      OP_PUSH:                   ok_nxt = (n < DEPTH_C);
      OP_ERA_SHIFT, OP_ERA_FAST,
      OP_READ:                   ok_nxt = (pos_in < n);
      OP_POP:                    ok_nxt = (n != '0);
      default:                   ok_nxt = 1'b1;
    endcase
  end

  // neighbour taps of each cell
  for (genvar g = 0; g < DEPTH; g++) begin : g_nb
    if (g == 0) begin : g_lo
      assign below[g] = '0;
    end else begin : g_lo
      assign below[g] = ent_r[g-1];
    end
    if (g == DEPTH - 1) begin : g_hi
      assign above[g] = '0;
    end else begin : g_hi
      assign above[g] = ent_r[g+1];
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_nxt[i] = ent_r[i];
      case (cmd.wr_mode)
        WR_INS_SHIFT: begin
          if (CMPW'(i) == pos_r) begin
            ent_nxt[i] = val_r;
          end else if (CMPW'(i) > pos_r && CMPW'(i) <= n) begin
            ent_nxt[i] = below[i];
          end
        end
        WR_INS_FAST: begin
          if (CMPW'(i) == pos_r) begin
            ent_nxt[i] = val_r;
          end else if (CMPW'(i) == n) begin
            ent_nxt[i] = item_r;
          end
        end
        WR_PUSH: begin
          if (CMPW'(i) == n) begin
            ent_nxt[i] = val_r;
          end
        end
        WR_ERA_SHIFT: begin
          if (CMPW'(i) >= pos_r && CMPW'(i) < last) begin
            ent_nxt[i] = above[i];
          end
        end
        WR_ERA_FAST: begin
          if (CMPW'(i) == pos_r) begin
            ent_nxt[i] = tmp_r;
          end
        end
        default: begin
          ent_nxt[i] = ent_r[i];
        end
      endcase
    end
  end

  always_comb begin
    case (cmd.cnt_op)
      CNT_INC: cnt_nxt = cnt_r + CW'(1);
      CNT_DEC: cnt_nxt = cnt_r - CW'(1);
      CNT_CLR: cnt_nxt = '0;
      default: cnt_nxt = cnt_r;
    endcase
  end

  assign iv = ok_r && (op_r inside {OP_ERA_SHIFT, OP_ERA_FAST, OP_POP, OP_READ});

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
    if (cmd.ld_in) begin
      op_r  <= in_opcode;
      pos_r <= pos_in;
      val_r <= ELEM_WIDTH'(in_value);
      ok_r  <= ok_nxt;
    end
    if (cmd.rd_item) begin
      item_r <= rdata;
    end
    if (cmd.rd_tmp) begin
      tmp_r <= rdata;
    end
    if (cmd.out_ld) begin
      out_ok         <= ok_r;
      out_item_valid <= iv;
      out_item_value <= iv ? VAL_W'(item_r) : '0;
      out_count      <= CNT_W'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> verif/tb.sv
// Self-checking testbench for the positional array list: directed table, then random ops.
`timescale 1ns / 100ps

module tb;
  import pal_pkg::*;

  localparam int LIST_DEPTH   = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1880;
  localparam int QUIET_TAIL   = 300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_PRINTS   = 60;

  typedef struct packed {
    logic        ok;
    logic        item_valid;
    logic [31:0] item_value;
    logic [4:0]  count;
  } list_result_t;

  typedef struct {
    opcode_t      op;
    logic [4:0]   pos;
    logic [31:0]  val;
    bit           typed;
    list_result_t want;
  } stim_row_t;

  typedef enum int {GROW, SHRINK, MIXED} op_mix_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_TD_W-1:0]  in_tdata = '0;
  opcode_t             in_tuser = OP_READ;
  logic                out_tvalid;
  logic                out_tready = 1'b1;
  logic [OUT_TD_W-1:0] out_tdata;
  logic                out_tuser;

  // sideband travelling with the driven beat: a typed expectation, if any
  logic         row_typed = 1'b0;
  list_result_t row_want = '0;
  logic         quiet = 1'b0;

  logic [31:0]  slots [LIST_DEPTH];
  int           fill = 0;
  list_result_t outcomes_due [$];
  list_result_t predicted, want;
  int           errors = 0;
  int           cycle_count = 0;
  int           stall_left = 0;

  positional_array_list_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  stim_row_t directed [24] = '{
    '{OP_READ,      5'd0,  32'h0,        1'b1, '{1'b0, 1'b0, 32'h0,        5'd0}},
    '{OP_POP,       5'd0,  32'h0,        1'b1, '{1'b0, 1'b0, 32'h0,        5'd0}},
    '{OP_ERA_SHIFT, 5'd0,  32'h0,        1'b1, '{1'b0, 1'b0, 32'h0,        5'd0}},
    '{OP_ERA_FAST,  5'd0,  32'h0,        1'b1, '{1'b0, 1'b0, 32'h0,        5'd0}},
    '{OP_INS_SHIFT, 5'd1,  32'h5,        1'b1, '{1'b0, 1'b0, 32'h0,        5'd0}},
    '{OP_INS_FAST,  5'd0,  32'hFFFFFFFF, 1'b1, '{1'b1, 1'b0, 32'h0,        5'd1}},
    '{OP_READ,      5'd0,  32'h0,        1'b1, '{1'b1, 1'b1, 32'hFFFFFFFF, 5'd1}},
    '{OP_INS_SHIFT, 5'd0,  32'h0,        1'b1, '{1'b1, 1'b0, 32'h0,        5'd2}},
    '{OP_PUSH,      5'd0,  32'hA5A55A5A, 1'b1, '{1'b1, 1'b0, 32'h0,        5'd3}},
    '{OP_INS_FAST,  5'd1,  32'h12345678, 1'b0, '0},
    '{OP_INS_SHIFT, 5'd4,  32'hDEADBEEF, 1'b0, '0},
    '{OP_READ,      5'd5,  32'h0,        1'b1, '{1'b0, 1'b0, 32'h0,        5'd5}},
    '{OP_READ,      5'd31, 32'h0,        1'b1, '{1'b0, 1'b0, 32'h0,        5'd5}},
    '{OP_INS_SHIFT, 5'd31, 32'h77777777, 1'b1, '{1'b0, 1'b0, 32'h0,        5'd5}},
    '{OP_ERA_SHIFT, 5'd1,  32'h0,        1'b0, '0},
    '{OP_ERA_FAST,  5'd0,  32'h0,        1'b0, '0},
    '{OP_ERA_FAST,  5'd2,  32'h0,        1'b0, '0},
    '{OP_POP,       5'd0,  32'h0,        1'b0, '0},
    '{OP_READ,      5'd0,  32'h0,        1'b0, '0},
    '{OP_ERA_SHIFT, 5'd0,  32'h0,        1'b0, '0},
    '{OP_PUSH,      5'd0,  32'h00000001, 1'b0, '0},
    '{OP_CLEAR,     5'd0,  32'h0,        1'b1, '{1'b1, 1'b0, 32'h0,        5'd0}},
    '{OP_CLEAR,     5'd0,  32'h0,        1'b1, '{1'b1, 1'b0, 32'h0,        5'd0}},
    '{OP_POP,       5'd0,  32'h0,        1'b1, '{1'b0, 1'b0, 32'h0,        5'd0}}
  };

  function automatic list_result_t list_outcome(opcode_t op, logic [4:0] pos,
                                                logic [31:0] val);
    list_result_t r;
    int n;
    r = '0;
    n = fill;
    case (op)
      OP_INS_SHIFT: if (pos <= n && n < LIST_DEPTH) begin
        for (int i = n; i > pos; i--) slots[i] = slots[i-1];
        slots[pos] = val;
        fill = n + 1;
        r.ok = 1'b1;
      end
      OP_INS_FAST: if (pos <= n && n < LIST_DEPTH) begin
        slots[n] = slots[pos];
        slots[pos] = val;
        fill = n + 1;
        r.ok = 1'b1;
      end
      OP_PUSH: if (n < LIST_DEPTH) begin
        slots[n] = val;
        fill = n + 1;
        r.ok = 1'b1;
      end
      OP_ERA_SHIFT: if (pos < n) begin
        r.item_value = slots[pos];
        for (int i = pos; i + 1 < n; i++) slots[i] = slots[i+1];
        fill = n - 1;
        r.ok = 1'b1;
        r.item_valid = 1'b1;
      end
      OP_ERA_FAST: if (pos < n) begin
        r.item_value = slots[pos];
        slots[pos] = slots[n-1];
        fill = n - 1;
        r.ok = 1'b1;
        r.item_valid = 1'b1;
      end
      OP_POP: if (n > 0) begin
        r.item_value = slots[n-1];
        fill = n - 1;
        r.ok = 1'b1;
        r.item_valid = 1'b1;
      end
      OP_CLEAR: begin
        fill = 0;
        r.ok = 1'b1;
      end
      default: if (pos < n) begin
        r.item_value = slots[pos];
        r.ok = 1'b1;
        r.item_valid = 1'b1;
      end
    endcase
    r.count = 5'(fill);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("[%0t] %s", $time, msg);
  endtask

  task automatic send_beat(opcode_t op, logic [4:0] pos, logic [31:0] val,
                           bit typed, list_result_t typed_want);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, val, pos};
    row_typed <= typed;
    row_want  <= typed_want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_list_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outcomes_due.size() != 0);
  endtask

  // receiver back-pressure in short bursts
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && in_tvalid && in_tready) begin
      predicted = list_outcome(in_tuser, in_tdata[4:0], in_tdata[36:5]);
      outcomes_due.push_back(row_typed ? row_want : predicted);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (outcomes_due.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing outstanding: tdata %h", out_tdata));
      end else begin
        want = outcomes_due.pop_front();
        if (out_tdata[0] !== want.ok)
          report_mismatch($sformatf("ok: got %b, want %b", out_tdata[0], want.ok));
        if (out_tuser !== want.item_valid)
          report_mismatch($sformatf("item_valid: got %b, want %b", out_tuser, want.item_valid));
        if (out_tdata[32:1] !== want.item_value)
          report_mismatch($sformatf("item_value: got %h, want %h", out_tdata[32:1],
                                    want.item_value));
        if (out_tdata[37:33] !== want.count)
          report_mismatch($sformatf("count: got %0d, want %0d", out_tdata[37:33], want.count));
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int          sent;
    int          seg_len;
    int          roll;
    op_mix_t     mode;
    opcode_t     op;
    logic [4:0]  pos;
    logic [31:0] val;

    sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[k])
      send_beat(directed[k].op, directed[k].pos, directed[k].val,
                directed[k].typed, directed[k].want);
    wait_list_idle();

    // first segment fills the list so the full-list refusals are hit early
    mode = GROW;
    seg_len = 40;
    while (sent < RANDOM_ITEMS) begin
      for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        case (mode)
          GROW:
            op = roll < 30 ? OP_INS_SHIFT : roll < 50 ? OP_INS_FAST :
                 roll < 75 ? OP_PUSH : opcode_t'($urandom_range(0, 7));
          SHRINK:
            op = roll < 30 ? OP_ERA_SHIFT : roll < 55 ? OP_ERA_FAST :
                 roll < 75 ? OP_POP : opcode_t'($urandom_range(0, 7));
          default: begin
            op = opcode_t'($urandom_range(0, 7));
            if (op == OP_CLEAR && roll < 85) op = OP_READ;
          end
        endcase
        if ($urandom_range(0, 9) < 8) pos = 5'($urandom_range(0, fill));
        else pos = 5'($urandom_range(0, 31));
        roll = $urandom_range(0, 9);
        val = roll == 0 ? 32'h0 : roll == 1 ? 32'hFFFFFFFF : 32'($urandom);
        if (sent == RANDOM_ITEMS / 2) wait_list_idle();
        if (sent == RANDOM_ITEMS - QUIET_TAIL) quiet <= 1'b1;
        send_beat(op, pos, val, 1'b0, '0);
        sent++;
      end
      mode = op_mix_t'($urandom_range(0, 2));
      seg_len = $urandom_range(10, 40);
    end

    wait_list_idle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
